// File: rtl/assert_macros.svh
// assertion helpers shared by the tokenizer rtl
// expects clk and rst_n (active low) in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// plain invariant checked at every rising clock edge
`define STU_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// same-cycle implication
`define STU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define STU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STU_ASSERT(label, expr, msg)
`define STU_ASSERT_IMP(label, ante, cons, msg)
`define STU_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/stu_pkg.sv
// shared codes, result record type and byte classifiers for the tokenizer
// no dependencies
`timescale 1ns / 1ps

package stu_pkg;

    // result kinds
    localparam logic [2:0] RK_TEXT  = 3'd0;
    localparam logic [2:0] RK_END   = 3'd1;
    localparam logic [2:0] RK_EOT   = 3'd2;
    localparam logic [2:0] RK_STOP  = 3'd3;
    localparam logic [2:0] RK_ERROR = 3'd4;

    // token kinds
    localparam logic [3:0] TK_NONE         = 4'd0;
    localparam logic [3:0] TK_DOT          = 4'd0;
    localparam logic [3:0] TK_INT          = 4'd1;
    localparam logic [3:0] TK_FLOAT        = 4'd2;
    localparam logic [3:0] TK_OPER         = 4'd3;
    localparam logic [3:0] TK_CHAR         = 4'd4;
    localparam logic [3:0] TK_STRING       = 4'd5;
    localparam logic [3:0] TK_PAREN_OPEN   = 4'd6;
    localparam logic [3:0] TK_PAREN_CLOSE  = 4'd7;
    localparam logic [3:0] TK_BRACE_OPEN   = 4'd8;
    localparam logic [3:0] TK_BRACE_CLOSE  = 4'd9;
    localparam logic [3:0] TK_SQUARE_OPEN  = 4'd10;
    localparam logic [3:0] TK_SQUARE_CLOSE = 4'd11;
    localparam logic [3:0] TK_IDENT        = 4'd12;

    // operator codes
    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_PLUS      = 5'd0;
    localparam logic [4:0] OP_MINUS     = 5'd2;
    localparam logic [4:0] OP_MUL       = 5'd4;
    localparam logic [4:0] OP_DIV       = 5'd6;
    localparam logic [4:0] OP_ASSIGN    = 5'd8;
    localparam logic [4:0] OP_NEQ       = 5'd10;
    localparam logic [4:0] OP_GE        = 5'd11;
    localparam logic [4:0] OP_SHIFTR    = 5'd12;
    localparam logic [4:0] OP_GT        = 5'd14;
    localparam logic [4:0] OP_LE        = 5'd15;
    localparam logic [4:0] OP_SHIFTL    = 5'd16;
    localparam logic [4:0] OP_LT        = 5'd18;
    localparam logic [4:0] OP_XOR       = 5'd19;
    localparam logic [4:0] OP_OR        = 5'd21;
    localparam logic [4:0] OP_AND       = 5'd23;

    // characters with a fixed role
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_US    = "_";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_LT    = "<";

    // reset value of the comment character
    localparam logic [7:0] CC_RESET = 8'd35;

    // results per byte and the bundle queue between front and back
    localparam int MAX_RES = 4;
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCNT_W  = QAW + 1;

    // position-free part of one result
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] tk;
        logic [4:0] op;
        logic [7:0] data;
    } res_info_t;

    localparam int INFO_W = $bits(res_info_t);

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } op_hit_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] kind;
    } br_hit_t;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        is_alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    // single-character operator starts
    function automatic op_hit_t op_lookup(input logic [7:0] b);
        op_hit_t r;
        r = '{hit: 1'b1, code: OP_NONE};
        case (b)
            "+":     r.code = OP_PLUS;
            "-":     r.code = OP_MINUS;
            "*":     r.code = OP_MUL;
            "/":     r.code = OP_DIV;
            "=":     r.code = OP_ASSIGN;
            "!":     r.code = OP_NEQ;
            ">":     r.code = OP_GT;
            "<":     r.code = OP_LT;
            "^":     r.code = OP_XOR;
            "|":     r.code = OP_OR;
            "&":     r.code = OP_AND;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // bracket tokens
    function automatic br_hit_t br_lookup(input logic [7:0] b);
        br_hit_t r;
        r = '{hit: 1'b1, kind: TK_NONE};
        case (b)
            "(":     r.kind = TK_PAREN_OPEN;
            ")":     r.kind = TK_PAREN_CLOSE;
            "{":     r.kind = TK_BRACE_OPEN;
            "}":     r.kind = TK_BRACE_CLOSE;
            "[":     r.kind = TK_SQUARE_OPEN;
            "]":     r.kind = TK_SQUARE_CLOSE;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/stu_front.sv
// front end: lexer state machine, takes one byte per transaction and
// builds the bundle of results it causes; depends on stu_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stu_front #(
    parameter int POS_WIDTH = 16,
    localparam int BUNDLE_W = stu_pkg::CNT_W
                            + stu_pkg::MAX_RES * (stu_pkg::INFO_W + 2 * POS_WIDTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          text_byte,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    output logic                bundle_we,
    output logic [BUNDLE_W-1:0] bundle
);
    import stu_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    typedef struct packed {
        res_info_t            info;
        logic [POS_WIDTH-1:0] row;
        logic [POS_WIDTH-1:0] col;
    } slot_t;

    typedef enum logic [8:0] {
        M_IDLE    = 9'b000000001,
        M_COMMENT = 9'b000000010,
        M_NUMBER  = 9'b000000100,
        M_NUMDOT  = 9'b000001000,
        M_IDENT   = 9'b000010000,
        M_OP1     = 9'b000100000,
        M_OP2     = 9'b001000000,
        M_CHARLIT = 9'b010000000,
        M_STRLIT  = 9'b100000000
    } mode_t;

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        sat_inc = (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic slot_t mk(input logic [2:0] k, input logic [3:0] tk,
                                 input logic [4:0] op, input logic [POS_WIDTH-1:0] r,
                                 input logic [POS_WIDTH-1:0] c, input logic [7:0] d);
        slot_t s;
        s.info = '{kind: k, tk: tk, op: op, data: d};
        s.row  = r;
        s.col  = c;
        return s;
    endfunction

    mode_t                mode_reg, mode_next;
    logic [POS_WIDTH-1:0] row_reg, row_next;
    logic [POS_WIDTH-1:0] col_reg, col_next;
    logic [POS_WIDTH-1:0] srow_reg, srow_next;
    logic [POS_WIDTH-1:0] scol_reg, scol_next;
    logic [4:0]           pop_reg, pop_next;
    logic                 dot_reg, dot_next;
    logic                 halt_reg, halt_next;
    logic [7:0]           cc_reg, cc_next;

    slot_t [MAX_RES-1:0]  slots;
    logic  [CNT_W-1:0]    n_res;

    // lexer step for one accepted byte
    always_comb
    begin
        logic [7:0] b;
        logic       idle_go;
        logic [4:0] op_eq;
        op_hit_t    oh;
        br_hit_t    bh;

        b         = text_byte;
        idle_go   = 1'b0;
        oh        = op_lookup(text_byte);
        bh        = br_lookup(text_byte);
        op_eq     = (pop_reg == OP_GT) ? OP_GE :
                    (pop_reg == OP_LT) ? OP_LE : pop_reg + 5'd1;
        mode_next = mode_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;
        pop_next  = pop_reg;
        dot_next  = dot_reg;
        halt_next = halt_reg;
        slots     = '0;
        n_res     = '0;

        if (take && b == CH_NUL)
        begin
            // end of text: close what is open, report, return to reset state but for the comment character
            if (!halt_reg)
            begin
                case (mode_reg)
                    M_NUMBER:
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, dot_reg ? TK_FLOAT : TK_INT,
                                                     OP_NONE, srow_reg, scol_reg, CH_NUL);
                        n_res = n_res + CNT_W'(1);
                    end
                    M_NUMDOT:
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_INT, OP_NONE,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res = n_res + CNT_W'(1);
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_DOT, OP_NONE,
                                                     row_reg, col_reg, CH_NUL);
                        n_res = n_res + CNT_W'(1);
                        col_next = sat_inc(col_next);
                    end
                    M_IDENT:
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_IDENT, OP_NONE,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res = n_res + CNT_W'(1);
                    end
                    M_OP1:
                    begin
                        if (pop_reg == OP_NEQ)
                            slots[n_res[IDX_W-1:0]] = mk(RK_STOP, TK_NONE, OP_NONE,
                                                         srow_reg, scol_reg, CH_NUL);
                        else
                            slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_OPER, pop_reg,
                                                         srow_reg, scol_reg, CH_NUL);
                        n_res = n_res + CNT_W'(1);
                    end
                    M_OP2:
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_OPER, pop_reg,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res = n_res + CNT_W'(1);
                    end
                    M_CHARLIT, M_STRLIT:
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_STOP, TK_NONE, OP_NONE,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res = n_res + CNT_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            slots[n_res[IDX_W-1:0]] = mk(RK_EOT, TK_NONE, OP_NONE, row_next, col_next, CH_NUL);
            n_res     = n_res + CNT_W'(1);
            mode_next = M_IDLE;
            row_next  = POS_ONE;
            col_next  = POS_ONE;
            srow_next = POS_ONE;
            scol_next = POS_ONE;
            pop_next  = OP_NONE;
            dot_next  = 1'b0;
            halt_next = 1'b0;
        end
        else if (take && !halt_reg)
        begin
            // byte inside a token or between tokens
            case (mode_reg)
                M_COMMENT:
                begin
                    if (b == CH_NL)
                        idle_go = 1'b1;
                end
                M_NUMBER:
                begin
                    if (is_digit(b))
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_TEXT, TK_NONE, OP_NONE,
                                                     srow_reg, scol_reg, b);
                        n_res    = n_res + CNT_W'(1);
                        col_next = sat_inc(col_next);
                    end
                    else if (b == CH_DOT && !dot_reg)
                        mode_next = M_NUMDOT;
                    else
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, dot_reg ? TK_FLOAT : TK_INT,
                                                     OP_NONE, srow_reg, scol_reg, CH_NUL);
                        n_res   = n_res + CNT_W'(1);
                        idle_go = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit(b))
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_TEXT, TK_NONE, OP_NONE,
                                                     srow_reg, scol_reg, CH_DOT);
                        n_res = n_res + CNT_W'(1);
                        slots[n_res[IDX_W-1:0]] = mk(RK_TEXT, TK_NONE, OP_NONE,
                                                     srow_reg, scol_reg, b);
                        n_res     = n_res + CNT_W'(1);
                        col_next  = sat_inc(sat_inc(col_next));
                        dot_next  = 1'b1;
                        mode_next = M_NUMBER;
                    end
                    else
                    begin
                        // number closes as int, the dot stands alone
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_INT, OP_NONE,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res = n_res + CNT_W'(1);
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_DOT, OP_NONE,
                                                     row_reg, col_reg, CH_NUL);
                        n_res    = n_res + CNT_W'(1);
                        col_next = sat_inc(col_next);
                        idle_go  = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || b == CH_US)
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_TEXT, TK_NONE, OP_NONE,
                                                     srow_reg, scol_reg, b);
                        n_res    = n_res + CNT_W'(1);
                        col_next = sat_inc(col_next);
                    end
                    else
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_IDENT, OP_NONE,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res   = n_res + CNT_W'(1);
                        idle_go = 1'b1;
                    end
                end
                M_OP1:
                begin
                    if (pop_reg == OP_NEQ)
                    begin
                        // bang must be followed by equals, else stop
                        if (b == CH_EQ)
                        begin
                            slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_OPER, OP_NEQ,
                                                         srow_reg, scol_reg, CH_NUL);
                            col_next = sat_inc(col_next);
                        end
                        else
                        begin
                            slots[n_res[IDX_W-1:0]] = mk(RK_STOP, TK_NONE, OP_NONE,
                                                         srow_reg, scol_reg, CH_NUL);
                            halt_next = 1'b1;
                        end
                        n_res     = n_res + CNT_W'(1);
                        mode_next = M_IDLE;
                    end
                    else if (b == CH_EQ)
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_OPER, op_eq,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res     = n_res + CNT_W'(1);
                        col_next  = sat_inc(col_next);
                        mode_next = M_IDLE;
                    end
                    else if ((pop_reg == OP_GT && b == CH_GT) ||
                             (pop_reg == OP_LT && b == CH_LT))
                    begin
                        pop_next  = (pop_reg == OP_GT) ? OP_SHIFTR : OP_SHIFTL;
                        col_next  = sat_inc(col_next);
                        mode_next = M_OP2;
                    end
                    else
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_OPER, pop_reg,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res   = n_res + CNT_W'(1);
                        idle_go = 1'b1;
                    end
                end
                M_OP2:
                begin
                    if (b == CH_EQ)
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_OPER, pop_reg + 5'd1,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res     = n_res + CNT_W'(1);
                        col_next  = sat_inc(col_next);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_OPER, pop_reg,
                                                     srow_reg, scol_reg, CH_NUL);
                        n_res   = n_res + CNT_W'(1);
                        idle_go = 1'b1;
                    end
                end
                M_CHARLIT, M_STRLIT:
                begin
                    if ((mode_reg == M_CHARLIT && b == CH_SQ) ||
                        (mode_reg == M_STRLIT && b == CH_DQ))
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END,
                                                     (mode_reg == M_CHARLIT) ? TK_CHAR
                                                                             : TK_STRING,
                                                     OP_NONE, srow_reg, scol_reg, CH_NUL);
                        mode_next = M_IDLE;
                    end
                    else
                        slots[n_res[IDX_W-1:0]] = mk(RK_TEXT, TK_NONE, OP_NONE,
                                                     srow_reg, scol_reg, b);
                    n_res    = n_res + CNT_W'(1);
                    col_next = sat_inc(col_next);
                end
                default:
                    idle_go = 1'b1;
            endcase

            // byte seen between tokens, after any token it closed
            if (idle_go)
            begin
                mode_next = M_IDLE;
                if (b == cc_reg)
                    mode_next = M_COMMENT;
                else if (is_space(b))
                begin
                    col_next = sat_inc(col_next);
                    if (b == CH_NL)
                    begin
                        row_next = sat_inc(row_next);
                        col_next = POS_ONE;
                    end
                end
                else
                begin
                    srow_next = row_next;
                    scol_next = col_next;
                    if (b == CH_DOT)
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, TK_DOT, OP_NONE,
                                                     row_next, col_next, CH_NUL);
                        n_res    = n_res + CNT_W'(1);
                        col_next = sat_inc(col_next);
                    end
                    else if (is_digit(b))
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_TEXT, TK_NONE, OP_NONE,
                                                     row_next, col_next, b);
                        n_res     = n_res + CNT_W'(1);
                        col_next  = sat_inc(col_next);
                        dot_next  = 1'b0;
                        mode_next = M_NUMBER;
                    end
                    else if (is_alpha(b) || b == CH_US)
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_TEXT, TK_NONE, OP_NONE,
                                                     row_next, col_next, b);
                        n_res     = n_res + CNT_W'(1);
                        col_next  = sat_inc(col_next);
                        mode_next = M_IDENT;
                    end
                    else if (b == CH_SQ)
                    begin
                        col_next  = sat_inc(col_next);
                        mode_next = M_CHARLIT;
                    end
                    else if (b == CH_DQ)
                    begin
                        col_next  = sat_inc(col_next);
                        mode_next = M_STRLIT;
                    end
                    else if (oh.hit)
                    begin
                        pop_next  = oh.code;
                        col_next  = sat_inc(col_next);
                        mode_next = M_OP1;
                    end
                    else if (bh.hit)
                    begin
                        slots[n_res[IDX_W-1:0]] = mk(RK_END, bh.kind, OP_NONE,
                                                     row_next, col_next, CH_NUL);
                        n_res    = n_res + CNT_W'(1);
                        col_next = sat_inc(col_next);
                    end
                    else
                    begin
                        // unknown byte: error and halt
                        slots[n_res[IDX_W-1:0]] = mk(RK_ERROR, TK_NONE, OP_NONE,
                                                     row_next, col_next, CH_NUL);
                        n_res     = n_res + CNT_W'(1);
                        halt_next = 1'b1;
                    end
                end
            end
        end
    end

    // comment character register
    always_comb
    begin
        cc_next = cfg_we ? cfg_data : cc_reg;
    end

    // lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            row_reg  <= POS_ONE;
            col_reg  <= POS_ONE;
            srow_reg <= POS_ONE;
            scol_reg <= POS_ONE;
            pop_reg  <= OP_NONE;
            dot_reg  <= 1'b0;
            halt_reg <= 1'b0;
            cc_reg   <= CC_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            srow_reg <= srow_next;
            scol_reg <= scol_next;
            pop_reg  <= pop_next;
            dot_reg  <= dot_next;
            halt_reg <= halt_next;
            cc_reg   <= cc_next;
        end
    end

    // bundle toward the queue
    assign bundle_we = take && (n_res != '0);
    assign bundle    = {n_res, slots};

    `STU_ASSERT_IMP(a_halt_idle, halt_reg, mode_reg == M_IDLE, "halted outside idle mode")
    `STU_ASSERT_NXT(a_eot_clears, take && text_byte == CH_NUL, mode_reg == M_IDLE && !halt_reg && row_reg == POS_ONE && col_reg == POS_ONE, "end of text did not clear lexer")

endmodule

// File: rtl/stu_queue.sv
// short register queue carrying result bundles from front to back
// depends on stu_pkg for its depth
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stu_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    import stu_pkg::*;

    logic [WIDTH-1:0]  entry_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = entry_reg[rd_ptr_reg];
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);

    `STU_ASSERT(a_q_no_overflow, !(wr_en && full), "bundle written into full queue")
    `STU_ASSERT(a_q_no_underflow, !(rd_en && empty), "bundle read from empty queue")

endmodule

// File: rtl/stu_back.sv
// back end: walks the head bundle one result at a time into the output
// register; depends on stu_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stu_back #(
    parameter int POS_WIDTH = 16,
    localparam int BUNDLE_W = stu_pkg::CNT_W
                            + stu_pkg::MAX_RES * (stu_pkg::INFO_W + 2 * POS_WIDTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BUNDLE_W-1:0]  q_data,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic                 pop,
    output logic                 empty,
    output logic [2:0]           result_kind,
    output logic [3:0]           token_kind,
    output logic [4:0]           operator_code,
    output logic [POS_WIDTH-1:0] token_row,
    output logic [POS_WIDTH-1:0] token_col,
    output logic [7:0]           out_byte,
    output logic                 last_of_step
);
    import stu_pkg::*;

    typedef struct packed {
        res_info_t            info;
        logic [POS_WIDTH-1:0] row;
        logic [POS_WIDTH-1:0] col;
    } slot_t;

    slot_t [MAX_RES-1:0] head_slots;
    logic  [CNT_W-1:0]   head_cnt;
    logic                head_last;
    logic                out_take;
    logic                load;

    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    slot_t               out_slot_reg;
    logic                out_last_reg;

    assign {head_cnt, head_slots} = q_data;

    // output register refills when empty or taken this cycle
    assign out_take  = pop && out_valid_reg;
    assign load      = !out_valid_reg || out_take;
    assign head_last = ((CNT_W'(slot_reg) + CNT_W'(1)) == head_cnt);
    assign q_pop     = load && !q_empty && head_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        slot_next      = slot_reg;
        if (load)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
                slot_next = head_last ? '0 : slot_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load && !q_empty)
        begin
            out_slot_reg <= head_slots[slot_reg];
            out_last_reg <= head_last;
        end
    end

    assign empty         = !out_valid_reg;
    assign result_kind   = out_slot_reg.info.kind;
    assign token_kind    = out_slot_reg.info.tk;
    assign operator_code = out_slot_reg.info.op;
    assign out_byte      = out_slot_reg.info.data;
    assign token_row     = out_slot_reg.row;
    assign token_col     = out_slot_reg.col;
    assign last_of_step  = out_last_reg;

    `STU_ASSERT_IMP(a_slot_has_head, slot_reg != '0, !q_empty, "mid-bundle with empty queue")

endmodule

// File: rtl/script_tokenizer_unit.sv
// top level of the streaming script tokenizer: front lexer, bundle queue, back
// depends on stu_pkg, stu_front, stu_queue, stu_back
`timescale 1ns / 1ps
//
// channel        direction  handshake            payload
// text input     in         push / full          text_byte
// configuration  in         cfg_valid / cfg_ready comment_char
// results        out        empty / pop          result_kind .. last_of_step
//
// a byte is taken whenever the bundle queue (4 bundles) has room;
// the front lexes it in that cycle and queues all results it causes.
// the back sends one result per cycle while pop is held; bytes keep being taken while
// earlier results wait in the queue. a result passes the queue, then the output register.
// rst_n clears all control state at once, no clearing pass; cfg_ready is always high.
// full rises when results come in faster than the result side takes them.

module script_tokenizer_unit #(
    parameter int POS_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           text_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           comment_char,
    output logic                 empty,
    input  logic                 pop,
    output logic [2:0]           result_kind,
    output logic [3:0]           token_kind,
    output logic [4:0]           operator_code,
    output logic [POS_WIDTH-1:0] token_row,
    output logic [POS_WIDTH-1:0] token_col,
    output logic [7:0]           out_byte,
    output logic                 last_of_step
);
    import stu_pkg::*;

    localparam int BUNDLE_W = CNT_W + MAX_RES * (INFO_W + 2 * POS_WIDTH);

    logic                take;
    logic                bundle_we;
    logic [BUNDLE_W-1:0] bundle;
    logic [BUNDLE_W-1:0] q_data;
    logic                q_empty;
    logic                q_pop;

    // input and configuration acceptance
    assign take      = push && !full;
    assign cfg_ready = 1'b1;

    stu_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .text_byte (text_byte),
        .cfg_we    (cfg_valid),
        .cfg_data  (comment_char),
        .bundle_we (bundle_we),
        .bundle    (bundle)
    );

    stu_queue #(
        .WIDTH (BUNDLE_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bundle_we),
        .wr_data (bundle),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    stu_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_data),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .result_kind   (result_kind),
        .token_kind    (token_kind),
        .operator_code (operator_code),
        .token_row     (token_row),
        .token_col     (token_col),
        .out_byte      (out_byte),
        .last_of_step  (last_of_step)
    );

endmodule

// File: tb/tb_script_tokenizer_unit.sv
// self-checking testbench for script_tokenizer_unit: byte-serial lexer with queue-style ports
// depends on stu_pkg and the rtl of script_tokenizer_unit; holds its own lexer model
`timescale 1ns / 1ps

module tb_script_tokenizer_unit;

    import stu_pkg::*;

    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam int PHASE_BYTES = 45;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [3:0] {
        LX_IDLE, LX_COMMENT, LX_NUMBER, LX_NUMDOT, LX_IDENT,
        LX_OP1, LX_OP2, LX_CHARLIT, LX_STRLIT
    } lex_mode_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] tk;
        logic [4:0] op;
        pos_t       row;
        pos_t       col;
        logic [7:0] data;
        logic       last;
    } tok_result_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       text_byte = 8'h00;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [7:0]       comment_char = CC_RESET;
    logic             empty;
    logic             pop = 1'b0;
    logic [2:0]       result_kind;
    logic [3:0]       token_kind;
    logic [4:0]       operator_code;
    pos_t             token_row;
    pos_t             token_col;
    logic [7:0]       out_byte;
    logic             last_of_step;

    // stimulus and scoreboard storage
    logic [7:0]       text_q [$];
    tok_result_t      token_results_q [$];
    tok_result_t      step_res [$];
    int unsigned      queued_total = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      stall_pct = 0;
    int unsigned      err_count = 0;
    logic             cfg_req = 1'b0;
    logic [7:0]       cfg_next = CC_RESET;

    // comment character of the phase being built
    logic [7:0]       cc_model_next = CC_RESET;

    // lexer model state
    lex_mode_t        mode_m;
    pos_t             row_m, col_m, srow_m, scol_m;
    logic [4:0]       pend_op_m;
    logic             dot_seen_m;
    logic             halted_m;
    logic [7:0]       cc_model;

    string op_text [25] = '{"+", "+=", "-", "-=", "*", "*=", "/", "/=", "=", "==", "!=",
                            ">=", ">>", ">>=", ">", "<=", "<<", "<<=", "<", "^", "^=",
                            "|", "|=", "&", "&="};

    script_tokenizer_unit #(
        .POS_WIDTH(POS_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .text_byte    (text_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .comment_char (comment_char),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .token_kind   (token_kind),
        .operator_code(operator_code),
        .token_row    (token_row),
        .token_col    (token_col),
        .out_byte     (out_byte),
        .last_of_step (last_of_step)
    );

    // byte classes
    function automatic logic digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic blank(input logic [7:0] b);
        return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic void clear_lexer();
        mode_m     = LX_IDLE;
        row_m      = 1;
        col_m      = 1;
        srow_m     = 1;
        scol_m     = 1;
        pend_op_m  = OP_NONE;
        dot_seen_m = 1'b0;
        halted_m   = 1'b0;
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [3:0] tk,
                                 input logic [4:0] op, input pos_t r, input pos_t c,
                                 input logic [7:0] d);
        tok_result_t x;
        if (step_res.size() >= MAX_RES)
            return;
        x = '{kind, tk, op, r, c, d, 1'b0};
        step_res.push_back(x);
    endfunction

    function automatic void close_token(input logic [3:0] tk, input logic [4:0] op);
        emit(RK_END, tk, op, srow_m, scol_m, CH_NUL);
    endfunction

    function automatic void adv_col();
        if (col_m != POS_MAX)
            col_m++;
    endfunction

    // byte seen between tokens
    function automatic void lex_idle(input logic [7:0] b);
        logic [4:0] op;
        logic       op_hit;
        logic [3:0] br;
        logic       br_hit;
        mode_m = LX_IDLE;
        op     = OP_NONE;
        op_hit = 1'b1;
        br     = TK_NONE;
        br_hit = 1'b1;
        if (b == cc_model) begin
            mode_m = LX_COMMENT;
            return;
        end
        if (blank(b)) begin
            adv_col();
            if (b == CH_NL) begin
                if (row_m != POS_MAX)
                    row_m++;
                col_m = 1;
            end
            return;
        end
        srow_m = row_m;
        scol_m = col_m;
        if (b == CH_DOT) begin
            close_token(TK_DOT, OP_NONE);
            adv_col();
            return;
        end
        if (digit(b)) begin
            emit(RK_TEXT, TK_NONE, OP_NONE, srow_m, scol_m, b);
            adv_col();
            dot_seen_m = 1'b0;
            mode_m = LX_NUMBER;
            return;
        end
        if (alpha(b) || b == CH_US) begin
            emit(RK_TEXT, TK_NONE, OP_NONE, srow_m, scol_m, b);
            adv_col();
            mode_m = LX_IDENT;
            return;
        end
        if (b == CH_SQ) begin
            adv_col();
            mode_m = LX_CHARLIT;
            return;
        end
        if (b == CH_DQ) begin
            adv_col();
            mode_m = LX_STRLIT;
            return;
        end
        case (b)
            "+":     op = OP_PLUS;
            "-":     op = OP_MINUS;
            "*":     op = OP_MUL;
            "/":     op = OP_DIV;
            "=":     op = OP_ASSIGN;
            "!":     op = OP_NEQ;
            ">":     op = OP_GT;
            "<":     op = OP_LT;
            "^":     op = OP_XOR;
            "|":     op = OP_OR;
            "&":     op = OP_AND;
            default: op_hit = 1'b0;
        endcase
        case (b)
            "(":     br = TK_PAREN_OPEN;
            ")":     br = TK_PAREN_CLOSE;
            "{":     br = TK_BRACE_OPEN;
            "}":     br = TK_BRACE_CLOSE;
            "[":     br = TK_SQUARE_OPEN;
            "]":     br = TK_SQUARE_CLOSE;
            default: br_hit = 1'b0;
        endcase
        if (op_hit) begin
            pend_op_m = op;
            adv_col();
            mode_m = LX_OP1;
            return;
        end
        if (br_hit) begin
            close_token(br, OP_NONE);
            adv_col();
            return;
        end
        // byte that starts nothing
        emit(RK_ERROR, TK_NONE, OP_NONE, row_m, col_m, CH_NUL);
        halted_m = 1'b1;
    endfunction

    // close the open token at end of text
    function automatic void close_pending();
        case (mode_m)
            LX_NUMBER: close_token(dot_seen_m ? TK_FLOAT : TK_INT, OP_NONE);
            LX_NUMDOT: begin
                close_token(TK_INT, OP_NONE);
                emit(RK_END, TK_DOT, OP_NONE, row_m, col_m, CH_NUL);
                adv_col();
            end
            LX_IDENT: close_token(TK_IDENT, OP_NONE);
            LX_OP1: begin
                if (pend_op_m == OP_NEQ)
                    emit(RK_STOP, TK_NONE, OP_NONE, srow_m, scol_m, CH_NUL);
                else
                    close_token(TK_OPER, pend_op_m);
            end
            LX_OP2: close_token(TK_OPER, pend_op_m);
            LX_CHARLIT, LX_STRLIT: emit(RK_STOP, TK_NONE, OP_NONE, srow_m, scol_m, CH_NUL);
            default: ;
        endcase
    endfunction

    // nonzero byte while not halted
    function automatic void scan_byte(input logic [7:0] b);
        logic [4:0] op;
        case (mode_m)
            LX_COMMENT: begin
                if (b == CH_NL)
                    lex_idle(b);
            end
            LX_NUMBER: begin
                if (digit(b)) begin
                    emit(RK_TEXT, TK_NONE, OP_NONE, srow_m, scol_m, b);
                    adv_col();
                end else if (b == CH_DOT && !dot_seen_m) begin
                    mode_m = LX_NUMDOT;
                end else begin
                    close_token(dot_seen_m ? TK_FLOAT : TK_INT, OP_NONE);
                    lex_idle(b);
                end
            end
            LX_NUMDOT: begin
                if (digit(b)) begin
                    emit(RK_TEXT, TK_NONE, OP_NONE, srow_m, scol_m, CH_DOT);
                    emit(RK_TEXT, TK_NONE, OP_NONE, srow_m, scol_m, b);
                    adv_col();
                    adv_col();
                    dot_seen_m = 1'b1;
                    mode_m = LX_NUMBER;
                end else begin
                    // number then a dot token, then the byte afresh
                    close_token(TK_INT, OP_NONE);
                    emit(RK_END, TK_DOT, OP_NONE, row_m, col_m, CH_NUL);
                    adv_col();
                    lex_idle(b);
                end
            end
            LX_IDENT: begin
                if (alpha(b) || digit(b) || b == CH_US) begin
                    emit(RK_TEXT, TK_NONE, OP_NONE, srow_m, scol_m, b);
                    adv_col();
                end else begin
                    close_token(TK_IDENT, OP_NONE);
                    lex_idle(b);
                end
            end
            LX_OP1: begin
                if (pend_op_m == OP_NEQ) begin
                    if (b == CH_EQ) begin
                        close_token(TK_OPER, OP_NEQ);
                        adv_col();
                    end else begin
                        // lone bang stops the block
                        emit(RK_STOP, TK_NONE, OP_NONE, srow_m, scol_m, CH_NUL);
                        halted_m = 1'b1;
                    end
                    mode_m = LX_IDLE;
                end else if (b == CH_EQ) begin
                    op = (pend_op_m == OP_GT) ? OP_GE :
                         (pend_op_m == OP_LT) ? OP_LE : pend_op_m + 5'd1;
                    close_token(TK_OPER, op);
                    adv_col();
                    mode_m = LX_IDLE;
                end else if ((pend_op_m == OP_GT && b == CH_GT) ||
                             (pend_op_m == OP_LT && b == CH_LT)) begin
                    pend_op_m = (pend_op_m == OP_GT) ? OP_SHIFTR : OP_SHIFTL;
                    adv_col();
                    mode_m = LX_OP2;
                end else begin
                    close_token(TK_OPER, pend_op_m);
                    lex_idle(b);
                end
            end
            LX_OP2: begin
                if (b == CH_EQ) begin
                    close_token(TK_OPER, pend_op_m + 5'd1);
                    adv_col();
                    mode_m = LX_IDLE;
                end else begin
                    close_token(TK_OPER, pend_op_m);
                    lex_idle(b);
                end
            end
            LX_CHARLIT, LX_STRLIT: begin
                if (b == ((mode_m == LX_CHARLIT) ? CH_SQ : CH_DQ)) begin
                    close_token((mode_m == LX_CHARLIT) ? TK_CHAR : TK_STRING, OP_NONE);
                    adv_col();
                    mode_m = LX_IDLE;
                end else begin
                    emit(RK_TEXT, TK_NONE, OP_NONE, srow_m, scol_m, b);
                    adv_col();
                end
            end
            default: lex_idle(b);
        endcase
    endfunction

    // expected results of one accepted byte
    function automatic void lex_step(input logic [7:0] b);
        step_res.delete();
        if (b == CH_NUL) begin
            if (!halted_m)
                close_pending();
            emit(RK_EOT, TK_NONE, OP_NONE, row_m, col_m, CH_NUL);
            clear_lexer();
        end else if (!halted_m) begin
            scan_byte(b);
        end
        if (step_res.size() != 0)
            step_res[step_res.size()-1].last = 1'b1;
        foreach (step_res[i])
            token_results_q.push_back(step_res[i]);
    endfunction

    // stimulus builders
    function automatic void queue_byte(input logic [7:0] b);
        text_q.push_back(b);
        queued_total++;
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endfunction

    function automatic logic [7:0] word_char(input logic first);
        int unsigned r;
        r = $urandom_range(first ? 52 : 62, 0);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return CH_US;
        return 8'("0" + r - 53);
    endfunction

    function automatic void queue_digits(input int unsigned n);
        for (int i = 0; i < n; i++)
            queue_byte(8'("0" + $urandom_range(9, 0)));
    endfunction

    // one random source text, mostly well-formed tokens, closed by a zero byte
    function automatic void add_random_text();
        int unsigned n_tok;
        int unsigned pick;
        int unsigned n;
        logic [7:0]  q;
        logic [7:0]  b;
        string       brackets;
        logic [7:0]  blanks [6];
        brackets = "()[]{}";
        blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        n_tok = $urandom_range(10, 1);
        for (int t = 0; t < n_tok; t++) begin
            pick = $urandom_range(99, 0);
            if (pick < 18) begin
                queue_byte(word_char(1'b1));
                n = $urandom_range(5, 0);
                for (int i = 0; i < n; i++)
                    queue_byte(word_char(1'b0));
            end else if (pick < 30) begin
                queue_digits($urandom_range(4, 1));
                n = $urandom_range(9, 0);
                if (n < 4) begin
                    queue_byte(CH_DOT);
                    queue_digits($urandom_range(3, 1));
                end else if (n == 4) begin
                    queue_byte(CH_DOT);
                end
            end else if (pick < 50) begin
                queue_text(op_text[$urandom_range(24, 0)]);
            end else if (pick < 58) begin
                queue_byte(brackets[$urandom_range(5, 0)]);
            end else if (pick < 62) begin
                queue_byte(CH_DOT);
            end else if (pick < 70) begin
                q = $urandom_range(1, 0) ? CH_SQ : CH_DQ;
                queue_byte(q);
                n = $urandom_range(4, 0);
                for (int i = 0; i < n; i++) begin
                    do b = 8'($urandom_range(255, 1)); while (b == q);
                    queue_byte(b);
                end
                // an open literal swallows the rest of the text
                if ($urandom_range(9, 0) != 0)
                    queue_byte(q);
            end else if (pick < 80) begin
                queue_byte(cc_model_next);
                n = $urandom_range(5, 0);
                for (int i = 0; i < n; i++) begin
                    do b = 8'($urandom_range(255, 1)); while (b == CH_NL);
                    queue_byte(b);
                end
                queue_byte(CH_NL);
            end else if (pick < 93) begin
                n = $urandom_range(2, 1);
                for (int i = 0; i < n; i++)
                    queue_byte(blanks[$urandom_range(5, 0)]);
            end else if (pick < 96) begin
                queue_byte(CH_BANG);
                do b = 8'($urandom_range(255, 1)); while (b == CH_EQ);
                queue_byte(b);
            end else begin
                queue_byte(8'($urandom_range(255, 1)));
            end
            if ($urandom_range(1, 0) != 0)
                queue_byte(8'h20);
        end
        queue_byte(CH_NUL);
    endfunction

    task automatic write_comment_char(input logic [7:0] v);
        cfg_next      = v;
        cc_model_next = v;
        cfg_req       = 1'b1;
        while (cfg_req)
            @(negedge clk);
    endtask

    // wait until every byte is taken and every result has come back
    task automatic drain();
        while (text_q.size() != 0 || token_results_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // byte driver, predicts on every accepted transaction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push      <= 1'b0;
            text_byte <= CH_NUL;
            clear_lexer();
            cc_model = CC_RESET;
        end else begin
            if (push && !full)
                lex_step(text_q.pop_front());
            if (text_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                push      <= 1'b1;
                text_byte <= text_q[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // comment character register writes
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_valid    <= 1'b0;
            comment_char <= CC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cfg_valid <= 1'b0;
            cc_model = comment_char;
            cfg_req  = 1'b0;
        end else if (cfg_req) begin
            cfg_valid    <= 1'b1;
            comment_char <= cfg_next;
        end
    end

    // result monitor and scoreboard
    always @(posedge clk or negedge rst_n) begin
        tok_result_t got;
        tok_result_t want;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = '{result_kind, token_kind, operator_code, token_row, token_col,
                        out_byte, last_of_step};
                if (token_results_q.size() == 0) begin
                    $display("%0t unexpected result:", $time,
                             " kind=%0d tk=%0d op=%0d", got.kind, got.tk, got.op,
                             " row=%0d col=%0d byte=%02h last=%0d",
                             got.row, got.col, got.data, got.last);
                    err_count++;
                end else begin
                    want = token_results_q.pop_front();
                    if (got.kind != want.kind || got.tk != want.tk || got.op != want.op ||
                        got.row != want.row || got.col != want.col ||
                        got.data != want.data || got.last != want.last) begin
                        $display("%0t mismatch:", $time,
                                 " expected kind=%0d tk=%0d op=%0d",
                                 want.kind, want.tk, want.op,
                                 " row=%0d col=%0d byte=%02h last=%0d",
                                 want.row, want.col, want.data, want.last,
                                 ", actual kind=%0d tk=%0d op=%0d",
                                 got.kind, got.tk, got.op,
                                 " row=%0d col=%0d byte=%02h last=%0d",
                                 got.row, got.col, got.data, got.last);
                        err_count++;
                    end
                end
            end
            pop <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // phase sequencer
    initial begin
        logic [7:0] cc_set [6];
        int unsigned mark;
        cc_set = '{CC_RESET, 8'd1, 8'd255, "/", 8'($urandom_range(255, 1)), "a"};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            write_comment_char(cc_set[ph]);
            if (ph == 0) begin
                // shift operator with assign, number then dot then ident, open char literal
                queue_text("<<= 7.f'x");
                queue_byte(CH_NUL);
                // lone bang, later bytes ignored
                queue_text("!x");
                queue_byte(CH_NUL);
                // top byte is unknown, block halts
                queue_byte(8'hFF);
                queue_byte("a");
                queue_byte(CH_NUL);
                // comment, then string holding a newline and a high byte
                queue_text("#c\n\"\n");
                queue_byte(8'h80);
                queue_byte(CH_DQ);
                // number left waiting on its dot at end of text
                queue_text("19.");
                queue_byte(CH_NUL);
            end
            mark = queued_total;
            while (queued_total - mark < PHASE_BYTES)
                add_random_text();
            drain();
        end
        repeat (20) @(negedge clk);
        if (err_count == 0 && token_results_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: script_tokenizer_unit.f
+incdir+rtl
rtl/stu_pkg.sv
rtl/stu_front.sv
rtl/stu_queue.sv
rtl/stu_back.sv
rtl/script_tokenizer_unit.sv
tb/tb_script_tokenizer_unit.sv
